// ===== rtl/core/ctr_pkg.sv =====
// shared types and fixed-point constants for the color temperature to rgb converter
// no dependencies; used by the top level and the testbench

package ctr_pkg;

    localparam logic [63:0] DEC9  = 64'd1000000000;
    localparam logic [63:0] DEC10 = 64'd10000000000;

    // gains and offsets q16, exponents q24, ln2 q30
    localparam logic [63:0] RED_GAIN    = ((64'd329698727446 << 16) + DEC9 / 2) / DEC9;
    localparam logic [63:0] RED_EXP     = ((64'd1332047592 << 24) + DEC10 / 2) / DEC10;
    localparam logic [63:0] GRN_LN_GAIN = ((64'd994708025861 << 16) + DEC10 / 2) / DEC10;
    localparam logic [63:0] GRN_LN_OFF  = ((64'd1611195681661 << 16) + DEC10 / 2) / DEC10;
    localparam logic [63:0] GRN_GAIN    = ((64'd2881221695283 << 16) + DEC10 / 2) / DEC10;
    localparam logic [63:0] GRN_EXP     = ((64'd755148492 << 24) + DEC10 / 2) / DEC10;
    localparam logic [63:0] BLU_GAIN    = ((64'd1385177312231 << 16) + DEC10 / 2) / DEC10;
    localparam logic [63:0] BLU_OFF     = ((64'd3050447927307 << 16) + DEC10 / 2) / DEC10;
    localparam logic [63:0] LN2_Q30     = ((64'd6931471806 << 30) + DEC10 / 2) / DEC10;

    // reciprocal of 25 for kelvin * 64 / 25
    localparam logic [63:0] DIV25_M = 64'd171798692;

    localparam int TW = 18;
    localparam logic [TW-1:0] T_ONE = 18'(256);
    localparam logic [TW-1:0] T_10  = 18'(10 * 256);
    localparam logic [TW-1:0] T_19  = 18'(19 * 256);
    localparam logic [TW-1:0] T_60  = 18'(60 * 256);
    localparam logic [TW-1:0] T_66  = 18'(66 * 256);

    localparam int LOG_STEPS = 16;
    localparam int POW_STEPS = 12;
    // input, operands, normalize, squarings, exponents, root products, shift, gain, output
    localparam int NSTG = 3 + LOG_STEPS + 1 + POW_STEPS + 3;

    // 2^(-2^-(i+1)) in q30
    localparam logic [29:0] NEG_ROOT [POW_STEPS] = '{
        30'(((64'd707106781 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd840896415 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd917004043 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd957603281 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd978572062 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd989228013 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd994599423 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd997296056 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd998647113 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd999323328 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd999661607 << 30) + DEC9 / 2) / DEC9),
        30'(((64'd999830789 << 30) + DEC9 / 2) / DEC9)
    };

    typedef struct packed {
        logic le66;
        logic ge66;
        logic le19;
        logic le1;
    } flags_t;

    typedef struct packed {
        flags_t          flags;
        logic [TW-1:0]   xa;
        logic [TW-1:0]   xb;
    } opnd_t;

    typedef struct packed {
        logic [30:0] m;
        logic [3:0]  ip;
        logic        z;
    } norm_t;

    typedef struct packed {
        flags_t      flags;
        logic [30:0] ma;
        logic [30:0] mb;
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic        za;
        logic        zb;
        logic [15:0] fa;
        logic [15:0] fb;
    } sq_t;

    typedef struct packed {
        flags_t      flags;
        logic [18:0] er;
        logic [18:0] eg;
        logic [30:0] vr;
        logic [30:0] vg;
        logic [27:0] lna;
        logic [27:0] lnb;
    } pw_t;

    typedef struct packed {
        flags_t      flags;
        logic [30:0] vr;
        logic [30:0] vg;
        logic [27:0] ga;
        logic [27:0] gb;
    } sh_t;

    typedef struct packed {
        flags_t      flags;
        logic [10:0] rp;
        logic [10:0] gp;
        logic [7:0]  glv;
        logic [7:0]  blv;
    } lv_t;

endpackage

// ===== rtl/core/ctr_if.sv =====
// valid/ready channel interfaces for temperature in and rgb levels out
// no dependencies

interface ctr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature_kelvin;

    modport source (output valid, output temperature_kelvin, input ready);
    modport sink (input valid, input temperature_kelvin, output ready);
endinterface

interface ctr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

// ===== rtl/core/color_temperature_to_rgb.sv =====
// color temperature to rgb levels, fully pipelined fixed-point curve fit
// depends on ctr_pkg and the channel interfaces in ctr_if.sv
//
//   channel  dir  payload                                   bits
//   temp     in   temperature_kelvin                        16
//   color    out  red_level, green_level, blue_level        8 each
//
// 35 register stages from temp transfer to color valid; one transfer per cycle while color is not stalled
// the depth is set by the 16 squaring stages of the log2 and the 12 root products
// reset clears only the valid bits, the pipeline comes up empty
// a stalled result holds the whole pipeline; temp.ready falls only while color is full
// and not taken

module color_temperature_to_rgb (
    input logic   clk,
    input logic   rst_n,
    ctr_in_if.sink    temp,
    ctr_out_if.source color
);
    import ctr_pkg::*;

    logic ce;
    logic [NSTG-1:0] vld_reg, vld_next;

    logic [TW-1:0] t_reg, t_next;
    logic [63:0]   t_prod;
    opnd_t         op_reg, op_next;
    sq_t           sq_reg [LOG_STEPS+1];
    sq_t           sq_next [LOG_STEPS+1];
    pw_t           pw_reg [POW_STEPS+1];
    pw_t           pw_next [POW_STEPS+1];
    sh_t           sh_reg, sh_next;
    lv_t           lv_reg, lv_next;
    logic [7:0]    red_reg, red_next, grn_reg, grn_next, blu_reg, blu_next;

    function automatic norm_t lognorm(input logic [TW-1:0] x);
        norm_t r;
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < TW; i++)
        begin
            if (x[i])
                p = 5'(i);
        end
        r.m  = 31'({13'b0, x} << (5'd30 - p));
        r.ip = 4'(p - 5'd8);
        r.z  = (p < 5'd8);
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic [12:0] v);
        return (v > 13'd255) ? 8'hFF : v[7:0];
    endfunction

    assign ce          = !vld_reg[NSTG-1] || color.ready;
    assign temp.ready  = ce;
    assign color.valid = vld_reg[NSTG-1];
    assign color.red_level   = red_reg;
    assign color.green_level = grn_reg;
    assign color.blue_level  = blu_reg;

    assign vld_next = {vld_reg[NSTG-2:0], temp.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= vld_next;
    end

    // t = kelvin * 256 / 100 in q8
    always_comb
    begin
        t_prod = {42'b0, temp.temperature_kelvin, 6'b0} * DIV25_M;
        t_next = t_prod[49:32];
    end

    always_comb
    begin
        op_next.flags.le66 = (t_reg <= T_66);
        op_next.flags.ge66 = (t_reg >= T_66);
        op_next.flags.le19 = (t_reg <= T_19);
        op_next.flags.le1  = (t_reg <= T_ONE);
        op_next.xa = (t_reg <= T_66) ? t_reg : t_reg - T_60;
        op_next.xb = t_reg - T_10;
    end

    always_comb
    begin
        norm_t na;
        norm_t nb;
        na = lognorm(op_reg.xa);
        nb = lognorm(op_reg.xb);
        sq_next[0].flags = op_reg.flags;
        sq_next[0].ma = na.m;
        sq_next[0].ia = na.ip;
        sq_next[0].za = na.z;
        sq_next[0].mb = nb.m;
        sq_next[0].ib = nb.ip;
        sq_next[0].zb = nb.z;
        sq_next[0].fa = '0;
        sq_next[0].fb = '0;
    end

    // log2 fraction, one bit per squaring
    for (genvar k = 0; k < LOG_STEPS; k++)
    begin : g_sq
        logic [61:0] pa, pb;
        always_comb
        begin
            pa = 62'(sq_reg[k].ma) * 62'(sq_reg[k].ma);
            pb = 62'(sq_reg[k].mb) * 62'(sq_reg[k].mb);
            sq_next[k+1] = sq_reg[k];
            sq_next[k+1].fa = {sq_reg[k].fa[14:0], pa[61]};
            sq_next[k+1].fb = {sq_reg[k].fb[14:0], pb[61]};
            sq_next[k+1].ma = pa[61] ? pa[61:31] : pa[60:30];
            sq_next[k+1].mb = pb[61] ? pb[61:31] : pb[60:30];
        end
    end

    // exponents and natural logs
    always_comb
    begin
        logic [19:0] la, lb;
        logic [63:0] pr, pg, pla, plb;
        la = sq_reg[LOG_STEPS].za ? 20'd0 : {sq_reg[LOG_STEPS].ia, sq_reg[LOG_STEPS].fa};
        lb = sq_reg[LOG_STEPS].zb ? 20'd0 : {sq_reg[LOG_STEPS].ib, sq_reg[LOG_STEPS].fb};
        pr  = 64'(la) * RED_EXP + (64'd1 << 23);
        pg  = 64'(la) * GRN_EXP + (64'd1 << 23);
        pla = 64'(la) * LN2_Q30 + (64'd1 << 21);
        plb = 64'(lb) * LN2_Q30 + (64'd1 << 21);
        pw_next[0].flags = sq_reg[LOG_STEPS].flags;
        pw_next[0].er  = pr[42:24];
        pw_next[0].eg  = pg[42:24];
        pw_next[0].vr  = 31'h4000_0000;
        pw_next[0].vg  = 31'h4000_0000;
        pw_next[0].lna = pla[49:22];
        pw_next[0].lnb = plb[49:22];
    end

    // 2^-e as a product of constant roots
    for (genvar i = 0; i < POW_STEPS; i++)
    begin : g_pw
        logic [63:0] qr, qg;
        always_comb
        begin
            qr = 64'(pw_reg[i].vr) * 64'(NEG_ROOT[i]) + (64'd1 << 29);
            qg = 64'(pw_reg[i].vg) * 64'(NEG_ROOT[i]) + (64'd1 << 29);
            pw_next[i+1] = pw_reg[i];
            if (pw_reg[i].er[15-i])
                pw_next[i+1].vr = qr[60:30];
            if (pw_reg[i].eg[15-i])
                pw_next[i+1].vg = qg[60:30];
        end
    end

    always_comb
    begin
        logic [63:0] qa, qb;
        qa = 64'(pw_reg[POW_STEPS].lna) * GRN_LN_GAIN + (64'd1 << 23);
        qb = 64'(pw_reg[POW_STEPS].lnb) * BLU_GAIN + (64'd1 << 23);
        sh_next.flags = pw_reg[POW_STEPS].flags;
        sh_next.vr = pw_reg[POW_STEPS].vr >> pw_reg[POW_STEPS].er[18:16];
        sh_next.vg = pw_reg[POW_STEPS].vg >> pw_reg[POW_STEPS].eg[18:16];
        sh_next.ga = qa[51:24];
        sh_next.gb = qb[51:24];
    end

    always_comb
    begin
        logic [63:0] qr, qg;
        logic [28:0] da, db;
        qr = 64'(sh_reg.vr) * RED_GAIN + (64'd1 << 45);
        qg = 64'(sh_reg.vg) * GRN_GAIN + (64'd1 << 45);
        da = 29'(sh_reg.ga) - 29'(GRN_LN_OFF) + 29'd32768;
        db = 29'(sh_reg.gb) - 29'(BLU_OFF) + 29'd32768;
        lv_next.flags = sh_reg.flags;
        lv_next.rp  = qr[56:46];
        lv_next.gp  = qg[56:46];
        lv_next.glv = (29'(sh_reg.ga) <= 29'(GRN_LN_OFF)) ? 8'd0 : sat8(da[28:16]);
        lv_next.blv = (29'(sh_reg.gb) <= 29'(BLU_OFF)) ? 8'd0 : sat8(db[28:16]);
    end

    always_comb
    begin
        red_next = lv_reg.flags.le66 ? 8'hFF : sat8({2'b0, lv_reg.rp});
        if (lv_reg.flags.le66)
            grn_next = lv_reg.flags.le1 ? 8'd0 : lv_reg.glv;
        else
            grn_next = sat8({2'b0, lv_reg.gp});
        if (lv_reg.flags.ge66)
            blu_next = 8'hFF;
        else if (lv_reg.flags.le19)
            blu_next = 8'd0;
        else
            blu_next = lv_reg.blv;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t_reg   <= t_next;
            op_reg  <= op_next;
            sq_reg  <= sq_next;
            pw_reg  <= pw_next;
            sh_reg  <= sh_next;
            lv_reg  <= lv_next;
            red_reg <= red_next;
            grn_reg <= grn_next;
            blu_reg <= blu_next;
        end
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        temp.valid && temp.ready |=> vld_reg[0])
        else $error("accepted temperature did not enter the pipeline");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_red_full: assert property (@(posedge clk) disable iff (!rst_n)
        ce && vld_reg[NSTG-2] && lv_reg.flags.le66 |=> color.red_level == 8'hFF)
        else $error("red not full scale at or below 6600 K");

    a_blue_full: assert property (@(posedge clk) disable iff (!rst_n)
        ce && vld_reg[NSTG-2] && lv_reg.flags.ge66 |=> color.blue_level == 8'hFF)
        else $error("blue not full scale at or above 6600 K");

endmodule

// ===== tb/sv/ctr_tb_if.sv =====
// testbench helper package: the expected color type and the idle modes
// the channel interfaces themselves come from the rtl file ctr_if.sv
// depends on nothing

package ctr_tb_pkg;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } rgb_t;

    typedef enum int {
        IDLE_SRC_HEAVY,
        IDLE_SNK_HEAVY,
        IDLE_NONE
    } idle_mode_t;

endpackage

// ===== tb/sv/color_temperature_to_rgb_tb.sv =====
// testbench for color_temperature_to_rgb: drives kelvin values with random gaps and stalls,
// predicts rgb levels in fixed point and checks each color transfer in order
// depends on ctr_pkg, ctr_if.sv, ctr_tb_if.sv and the rtl top level

module color_temperature_to_rgb_tb;
    import ctr_pkg::*;
    import ctr_tb_pkg::*;

    class rgb_scoreboard;
        rgb_t pending[$];
        int   errors;

        function automatic logic [31:0] log2_q16(logic [31:0] x);
            int          p;
            logic [63:0] m;
            logic [31:0] frac;
            p = 0;
            frac = 0;
            while (p < 31 && (x >> (p + 1)) != 0)
                p++;
            if (p < 8)
                return 0;
            m = 64'(x) << (30 - p);
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    frac[0] = 1'b1;
                end
            end
            return (32'(p - 8) << 16) | frac;
        endfunction

        function automatic logic [63:0] pow2_neg(logic [63:0] e);
            logic [63:0] n;
            logic [63:0] v;
            n = e >> 16;
            v = 64'd1 << 30;
            for (int i = 0; i < POW_STEPS; i++)
                if (e[15 - i])
                    v = (v * 64'(NEG_ROOT[i]) + (64'd1 << 29)) >> 30;
            if (n >= 31)
                return 0;
            return v >> n;
        endfunction

        function automatic logic [7:0] sat(logic [63:0] v);
            return v > 255 ? 8'd255 : v[7:0];
        endfunction

        function automatic logic [7:0] power_level(logic [31:0] d, logic [63:0] expo,
                                                   logic [63:0] gain);
            logic [63:0] e;
            e = (64'(log2_q16(d)) * expo + (64'd1 << 23)) >> 24;
            return sat((gain * pow2_neg(e) + (64'd1 << 45)) >> 46);
        endfunction

        function automatic logic [7:0] log_level(logic [31:0] x, logic [63:0] gain,
                                                 logic [63:0] off);
            logic [63:0] ln24;
            logic [63:0] g;
            ln24 = (64'(log2_q16(x)) * LN2_Q30 + (64'd1 << 21)) >> 22;
            g = (gain * ln24 + (64'd1 << 23)) >> 24;
            if (g <= off)
                return 0;
            return sat((g - off + 64'd32768) >> 16);
        endfunction

        function void note_temperature(logic [15:0] kelvin);
            logic [31:0] t;
            rgb_t        c;
            t = (32'(kelvin) * 256) / 100;
            if (t <= 32'(T_66))
            begin
                c.red_level = 8'd255;
                c.green_level = (t <= 32'(T_ONE)) ? 8'd0 : log_level(t, GRN_LN_GAIN, GRN_LN_OFF);
            end
            else
            begin
                c.red_level = power_level(t - 32'(T_60), RED_EXP, RED_GAIN);
                c.green_level = power_level(t - 32'(T_60), GRN_EXP, GRN_GAIN);
            end
            if (t >= 32'(T_66))
                c.blue_level = 8'd255;
            else if (t <= 32'(T_19))
                c.blue_level = 8'd0;
            else
                c.blue_level = log_level(t - 32'(T_10), BLU_GAIN, BLU_OFF);
            pending.insert(pending.size(), c);
        endfunction

        function void check_color(rgb_t got);
            rgb_t want;
            if (pending.size() == 0)
            begin
                $error("color transfer with nothing expected: %0d %0d %0d",
                       got.red_level, got.green_level, got.blue_level);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red_level !== want.red_level)
            begin
                $error("red_level expected %0d actual %0d", want.red_level, got.red_level);
                errors++;
            end
            if (got.green_level !== want.green_level)
            begin
                $error("green_level expected %0d actual %0d", want.green_level, got.green_level);
                errors++;
            end
            if (got.blue_level !== want.blue_level)
            begin
                $error("blue_level expected %0d actual %0d", want.blue_level, got.blue_level);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 34;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    ctr_in_if  temp ();
    ctr_out_if color ();

    rgb_scoreboard levels_sb;
    idle_mode_t    idle_mode;
    bit            hold_color;
    int            quiet_cycles;

    color_temperature_to_rgb dut (
        .clk   (clk),
        .rst_n (rst_n),
        .temp  (temp.sink),
        .color (color.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SRC_HEAVY: return $urandom_range(99) < 34;
            IDLE_SNK_HEAVY: return $urandom_range(99) < 47;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_mode)
            IDLE_SRC_HEAVY: return $urandom_range(99) < 47;
            IDLE_SNK_HEAVY: return $urandom_range(99) < 34;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic send_temperature(logic [15:0] kelvin);
        while (sender_idles())
        begin
            temp.valid <= 1'b0;
            @(negedge clk);
        end
        temp.valid <= 1'b1;
        temp.temperature_kelvin <= kelvin;
        @(posedge clk);
        while (!temp.ready)
            @(posedge clk);
        levels_sb.note_temperature(kelvin);
        @(negedge clk);
    endtask

    function automatic logic [15:0] random_kelvin();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($urandom_range(200));
            2:       return 16'($urandom_range(1850, 1950));
            3:       return 16'($urandom_range(6500, 6700));
            4:       return 16'($urandom_range(12000, 40000));
            default: return 16'($urandom_range(1000, 12000));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && color.valid && color.ready)
            levels_sb.check_color('{color.red_level, color.green_level, color.blue_level});
    end

    always @(negedge clk)
    begin
        if (hold_color)
            color.ready <= 1'b0;
        else
            color.ready <= !receiver_idles();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (temp.valid && temp.ready) || (color.valid && color.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int hold_count;
        @(negedge clk);
        while (levels_sb == null)
            @(negedge clk);
        @(posedge clk);
        while (!(temp.valid && temp.ready))
            @(posedge clk);
        @(negedge clk);
        hold_color = 1'b1;
        hold_count = 0;
        while (hold_count < 3 * LATENCY)
        begin
            @(negedge clk);
            hold_count++;
        end
        hold_color = 1'b0;
    end

    initial
    begin
        logic [15:0] directed[] = '{16'd0, 16'd50, 16'd99, 16'd100, 16'd101, 16'd199,
                                    16'd1000, 16'd1899, 16'd1900, 16'd1901, 16'd2000,
                                    16'd6599, 16'd6600, 16'd6601, 16'd6640, 16'd6700,
                                    16'd10000, 16'd32768, 16'd43690, 16'd21845, 16'd65535};
        int drain;
        levels_sb = new();
        idle_mode = IDLE_SRC_HEAVY;
        hold_color = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        temp.valid = 1'b0;
        temp.temperature_kelvin = '0;
        color.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed[i])
            send_temperature(directed[i]);
        for (int i = 0; i < 600; i++)
        begin
            if (i == 200)
                idle_mode = IDLE_SNK_HEAVY;
            if (i == 400)
                idle_mode = IDLE_NONE;
            send_temperature(random_kelvin());
        end
        temp.valid <= 1'b0;
        while (levels_sb.pending.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 2 * LATENCY)
        begin
            @(posedge clk);
            drain++;
        end
        if (levels_sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
